// ===== hdl/mdsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the module-file sample decoder.
// No dependencies; imported by every module of the block.
package mdsd_pkg;

	// Byte offset counter width and saturation value
	localparam int unsigned OFF_W   = 22;
	localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

	// Fixed header layout pieces
	localparam int unsigned TITLE_BYTES     = 20;
	localparam int unsigned INSTR_REC_BYTES = 30;
	localparam int unsigned LEN_HI_POS      = 22;
	localparam int unsigned LEN_LO_POS      = 23;
	localparam int unsigned PATTERN_ROWS    = 64;
	localparam int unsigned SEQUENCE_LENGTH = 128;
	localparam int unsigned TAG_BYTES       = 4;

	// Byte kinds found by the front end
	localparam logic [1:0] KIND_PLAIN  = 2'd0;
	localparam logic [1:0] KIND_LEN_HI = 2'd1;
	localparam logic [1:0] KIND_LEN_LO = 2'd2;
	localparam logic [1:0] KIND_SEQ    = 2'd3;

	// Decoder phases, also the output region codes
	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_PATTERN = 2'd1;
	localparam logic [1:0] PH_SAMPLE  = 2'd2;
	localparam logic [1:0] PH_BEYOND  = 2'd3;

	// One classified byte travelling from front to back
	typedef struct packed {
		logic [7:0]       data;
		logic             last;
		logic [1:0]       kind;
		logic             hdr_end;
		logic [OFF_W-1:0] off;
	} item_t;

	// Back-end status seen by the top level
	typedef struct packed {
		logic [1:0] phase;
		logic       pop;
		logic       list_empty;
	} back_status_t;

endpackage

// ===== hdl/mdsd_front.sv =====
`timescale 1ns / 1ps
// Front end: counts input bytes and tags each with its header role.
// Depends on mdsd_pkg.
module mdsd_front import mdsd_pkg::*; #(
	parameter int unsigned NUM_INSTRUMENTS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	input  logic       in_last,
	output logic       item_valid,
	input  logic       item_ready,
	output item_t      item
);

	localparam int unsigned SEQ_START    = TITLE_BYTES + INSTR_REC_BYTES * NUM_INSTRUMENTS + 2;
	localparam int unsigned HEADER_BYTES = SEQ_START + SEQUENCE_LENGTH + TAG_BYTES;
	localparam int unsigned REC_END      = SEQ_START - 2;

	logic [OFF_W-1:0] off_q;
	logic [4:0]       rec_pos_q;
	logic             in_recs;
	logic             in_seq;
	logic             xfer;

	assign in_ready   = item_ready;
	assign item_valid = in_valid;
	assign xfer       = in_valid && item_ready;

	assign in_recs = (off_q >= OFF_W'(TITLE_BYTES)) && (off_q < OFF_W'(REC_END));
	assign in_seq  = (off_q >= OFF_W'(SEQ_START)) &&
		(off_q < OFF_W'(SEQ_START + SEQUENCE_LENGTH));

	// Classify the current byte from its offset
	always_comb begin
		item.data    = in_data;
		item.last    = in_last;
		item.off     = off_q;
		item.hdr_end = (off_q == OFF_W'(HEADER_BYTES - 1));
		item.kind    = KIND_PLAIN;
		if (in_recs && rec_pos_q == 5'(LEN_HI_POS)) begin
			item.kind = KIND_LEN_HI;
		end else if (in_recs && rec_pos_q == 5'(LEN_LO_POS)) begin
			item.kind = KIND_LEN_LO;
		end else if (in_seq) begin
			item.kind = KIND_SEQ;
		end
	end

	// Saturating byte offset and position within an instrument record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q     <= '0;
			rec_pos_q <= '0;
		end else if (xfer) begin
			if (off_q != OFF_MAX) begin
				off_q <= off_q + 1'b1;
			end
			if (in_recs) begin
				rec_pos_q <= (rec_pos_q == 5'(INSTR_REC_BYTES - 1)) ? '0 : rec_pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== hdl/mdsd_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue between the front and back ends.
// Depends on mdsd_pkg for the item type.
module mdsd_queue import mdsd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/mdsd_back.sv =====
`timescale 1ns / 1ps
// Back end: header capture, pattern skip, delta decoding and size check,
// with the output register. Depends on mdsd_pkg.
module mdsd_back import mdsd_pkg::*; #(
	parameter int unsigned NUM_INSTRUMENTS = 31,
	parameter int unsigned NUM_VOICES      = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_ready,
	input  item_t        item,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   out_byte,
	output logic [1:0]   out_region,
	output logic         out_mismatch,
	output back_status_t status
);

	localparam int unsigned SEQ_START    = TITLE_BYTES + INSTR_REC_BYTES * NUM_INSTRUMENTS + 2;
	localparam int unsigned HEADER_BYTES = SEQ_START + SEQUENCE_LENGTH + TAG_BYTES;
	localparam int unsigned PATT_BYTES   = PATTERN_ROWS * NUM_VOICES * 4;
	localparam int unsigned CNT_W        = $clog2(NUM_INSTRUMENTS + 1);
	localparam int unsigned IDX_W        = $clog2(NUM_INSTRUMENTS);
	localparam int unsigned SUM_W        = 16 + CNT_W;

	logic [1:0]       phase_q;
	logic [7:0]       hi_q;
	logic [7:0]       max_q;
	logic [OFF_W-1:0] patt_end_q;
	logic [SUM_W-1:0] sum_q;
	logic [15:0]      len_list_q [NUM_INSTRUMENTS];
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] k_q;
	logic [15:0]      pos_q;
	logic [7:0]       prev_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic [1:0]       out_region_q;
	logic             out_mis_q;

	logic             pop;
	logic [15:0]      new_len;
	logic [15:0]      cur_len;
	logic [16:0]      pos_inc;
	logic             convert;
	logic             smp_done;
	logic [CNT_W-1:0] k_inc;
	logic [7:0]       result;
	logic             mismatch;

	assign pop        = item_valid && (!out_valid_q || out_ready);
	assign item_ready = !out_valid_q || out_ready;

	// Length in bytes from the captured word count, wrapped to 16 bits
	assign new_len = {hi_q[6:0], item.data, 1'b0};

	// Current sample and delta conversion
	assign cur_len  = len_list_q[k_q[IDX_W-1:0]];
	assign pos_inc  = {1'b0, pos_q} + 17'd1;
	assign convert  = (pos_q != 16'd0) && (pos_inc < {1'b0, cur_len});
	assign smp_done = (pos_inc >= {1'b0, cur_len});
	assign k_inc    = k_q + 1'b1;
	assign result   = (phase_q == PH_SAMPLE && convert) ? item.data + prev_q : item.data;

	// Expected size is pattern end + 1 + sample bytes; compare against offset
	assign mismatch = item.last &&
		((item.off == OFF_MAX) || (item.off != patt_end_q + OFF_W'(sum_q)));

	// Nonempty sample lengths, in instrument order
	always_ff @(posedge clk) begin
		if (pop && phase_q == PH_HEADER && item.kind == KIND_LEN_LO && new_len != 16'd0) begin
			len_list_q[cnt_q[IDX_W-1:0]] <= new_len;
		end
	end

	// Decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			hi_q       <= '0;
			max_q      <= '0;
			patt_end_q <= OFF_W'(HEADER_BYTES - 1 + PATT_BYTES);
			sum_q      <= '0;
			cnt_q      <= '0;
			k_q        <= '0;
			pos_q      <= '0;
			prev_q     <= '0;
		end else if (pop) begin
			case (phase_q)
				PH_HEADER: begin
					case (item.kind)
						KIND_LEN_HI: begin
							hi_q <= item.data;
						end
						KIND_LEN_LO: begin
							sum_q <= sum_q + SUM_W'(new_len);
							if (new_len != 16'd0) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						KIND_SEQ: begin
							if (item.data > max_q) begin
								max_q      <= item.data;
								patt_end_q <= OFF_W'(HEADER_BYTES - 1) +
									OFF_W'((OFF_W'(item.data) + 1'b1) * OFF_W'(PATT_BYTES));
							end
						end
						default: begin
						end
					endcase
					if (item.hdr_end) begin
						phase_q <= PH_PATTERN;
					end
				end
				PH_PATTERN: begin
					if (item.off == patt_end_q) begin
						k_q     <= '0;
						pos_q   <= '0;
						phase_q <= (cnt_q != '0) ? PH_SAMPLE : PH_BEYOND;
					end
				end
				PH_SAMPLE: begin
					prev_q <= result;
					if (smp_done) begin
						k_q   <= k_inc;
						pos_q <= '0;
						if (k_inc == cnt_q) begin
							phase_q <= PH_BEYOND;
						end
					end else begin
						pos_q <= pos_inc[15:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q   <= result;
			out_region_q <= phase_q;
			out_mis_q    <= mismatch;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_region   = out_region_q;
	assign out_mismatch = out_mis_q;

	assign status.phase      = phase_q;
	assign status.pop        = pop;
	assign status.list_empty = (cnt_q == '0);

endmodule

// ===== hdl/mod_delta_sample_stream_decoder.sv =====
`timescale 1ns / 1ps
// Top level of the module-file delta sample decoder.
// Depends on mdsd_pkg, mdsd_front, mdsd_queue and mdsd_back.
//
// Channel   Dir  tdata                  tuser / tlast
// s_axis    in   [7:0] data_byte        tlast: is_last
// m_axis    out  [7:0] out_byte         tuser: [1:0] region, [2] size_mismatch
//
// One byte per clock cycle sustained when m_axis does not stall. A byte is written
// into the two-entry queue at its input transfer and then moves into the output
// register, from which it leaves at m_axis. The per-byte work is one 8-bit add and
// 22-bit offset compares in the back end. Reset clears all control state and needs
// no clearing pass. A stall at m_axis backs up through the queue to s_axis tready.
module mod_delta_sample_stream_decoder import mdsd_pkg::*; #(
	parameter int unsigned NUM_INSTRUMENTS = 31,
	parameter int unsigned NUM_VOICES      = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [2:0] m_axis_tuser   // [1:0] region, [2] size_mismatch
);

	item_t        fr_item;
	logic         fr_valid;
	logic         fr_ready;
	item_t        bk_item;
	logic         bk_valid;
	logic         bk_ready;
	logic [1:0]   region;
	logic         size_mismatch;
	back_status_t status;

	mdsd_front #(
		.NUM_INSTRUMENTS(NUM_INSTRUMENTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.item_valid(fr_valid),
		.item_ready(fr_ready),
		.item      (fr_item)
	);

	mdsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(fr_valid),
		.push_ready(fr_ready),
		.push_item (fr_item),
		.pop_valid (bk_valid),
		.pop_ready (bk_ready),
		.pop_item  (bk_item)
	);

	mdsd_back #(
		.NUM_INSTRUMENTS(NUM_INSTRUMENTS),
		.NUM_VOICES     (NUM_VOICES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (bk_valid),
		.item_ready  (bk_ready),
		.item        (bk_item),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_byte    (m_axis_tdata),
		.out_region  (region),
		.out_mismatch(size_mismatch),
		.status      (status)
	);

	assign m_axis_tuser = {size_mismatch, region};

	// Sample phase is only entered when at least one sample is nonempty
	a_sample_has_list: assert property (@(posedge clk) disable iff (!arst_n)
		(status.phase == PH_SAMPLE) |-> !status.list_empty)
		else $error("sample phase with no nonempty sample");

	// Past the expected end the decoder stays there until reset
	a_beyond_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(status.phase == PH_BEYOND) |=> (status.phase == PH_BEYOND))
		else $error("left beyond-end phase");

	// A stalled result is never overwritten by a new queue pop
	a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !status.pop)
		else $error("queue popped while output stalled");

endmodule

// ===== tb/mod_delta_sample_stream_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mod_delta_sample_stream_decoder: streams one module file
// (header, patterns, sample bodies, trailing bytes) and scores every output transfer.
// Depends on mdsd_pkg and the decoder RTL.
module mod_delta_sample_stream_decoder_test;
	import mdsd_pkg::*;

	localparam int unsigned NUM_INSTR    = 31;
	localparam int unsigned VOICES       = 4;
	localparam int unsigned SEQ_START    = TITLE_BYTES + INSTR_REC_BYTES * NUM_INSTR + 2;
	localparam int unsigned HDR_BYTES    = SEQ_START + SEQUENCE_LENGTH + TAG_BYTES;
	localparam int unsigned PAT_BYTES    = PATTERN_ROWS * VOICES * 4;
	localparam int unsigned TOP_PATTERN  = 0;
	localparam int unsigned TAIL_BYTES   = 40;
	localparam int unsigned LIMIT_CYCLES = 1_500_000;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] region;
		logic       size_mismatch;
	} dec_result_t;

	// Decoder model plus the queue of results still owed by the block
	class sample_decode_scoreboard;
		logic [OFF_W-1:0] offset;
		logic [15:0]      lens [NUM_INSTR];
		logic [7:0]       len_hi;
		logic [7:0]       top_pattern;
		logic [7:0]       last_out;
		logic [1:0]       phase;
		int unsigned      inst;
		int unsigned      pos;
		dec_result_t      owed_bytes [$];
		int unsigned      failures;
		int unsigned      checked;
		int unsigned      flags_seen;

		function new();
			offset      = '0;
			len_hi      = '0;
			top_pattern = '0;
			last_out    = '0;
			phase       = PH_HEADER;
			inst        = 0;
			pos         = 0;
			failures    = 0;
			checked     = 0;
			flags_seen  = 0;
			foreach (lens[i]) lens[i] = '0;
		endfunction

		// Skip empty instruments; past the last one everything is beyond the end
		function void seek_sample();
			while (inst < NUM_INSTR && lens[inst] == 16'd0) inst++;
			pos   = 0;
			phase = (inst < NUM_INSTR) ? PH_SAMPLE : PH_BEYOND;
		endfunction

		function int unsigned file_size();
			int unsigned total;
			total = HDR_BYTES + (int'(top_pattern) + 1) * PAT_BYTES;
			foreach (lens[i]) total += lens[i];
			return total;
		endfunction

		function int unsigned pending();
			return owed_bytes.size();
		endfunction

		function void take_input(logic [7:0] data, logic last);
			dec_result_t r;
			int unsigned off;
			int unsigned rel;
			int unsigned len;
			off             = offset;
			r.out_byte      = data;
			r.region        = phase;
			r.size_mismatch = 1'b0;
			case (phase)
				PH_HEADER: begin
					// Length words live in the instrument records, max pattern in the sequence
					if (off >= TITLE_BYTES && off < SEQ_START - 2) begin
						rel = (off - TITLE_BYTES) % INSTR_REC_BYTES;
						if (rel == LEN_HI_POS)
							len_hi = data;
						else if (rel == LEN_LO_POS)
							lens[(off - TITLE_BYTES) / INSTR_REC_BYTES] = {len_hi[6:0], data, 1'b0};
					end else if (off >= SEQ_START && off < SEQ_START + SEQUENCE_LENGTH) begin
						if (data > top_pattern) top_pattern = data;
					end
					if (off == HDR_BYTES - 1) phase = PH_PATTERN;
				end
				PH_PATTERN: begin
					if (off == HDR_BYTES + (int'(top_pattern) + 1) * PAT_BYTES - 1) begin
						inst = 0;
						seek_sample();
					end
				end
				PH_SAMPLE: begin
					// Inner bytes accumulate deltas; first and last byte pass as coded
					len = lens[inst];
					if (pos >= 1 && pos + 1 < len) r.out_byte = data + last_out;
					last_out = r.out_byte;
					pos++;
					if (pos >= len) begin
						inst++;
						seek_sample();
					end
				end
				PH_BEYOND: ;
			endcase
			if (last) begin
				flags_seen++;
				r.size_mismatch = (offset == OFF_MAX) || (off + 1 != file_size());
			end
			if (offset != OFF_MAX) offset++;
			owed_bytes.push_back(r);
		endfunction

		function void check_result(logic [7:0] data, logic [2:0] user);
			dec_result_t want;
			checked++;
			if (owed_bytes.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("output transfer %0d with nothing owed: byte %02h tuser %03b",
						checked, data, user);
				return;
			end
			want = owed_bytes.pop_front();
			if (data !== want.out_byte || user[1:0] !== want.region ||
				user[2] !== want.size_mismatch) begin
				failures++;
				if (failures <= 10)
					$display({"transfer %0d: expected byte %02h region %0d flag %0b, ",
						"got byte %02h region %0d flag %0b"},
						checked, want.out_byte, want.region, want.size_mismatch,
						data, user[1:0], user[2]);
			end
		endfunction
	endclass

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = 8'd0;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;

	logic        calm     = 1'b0;
	logic        hold_off = 1'b0;
	int unsigned results_seen = 0;
	logic [8:0]  stim_q [$];   // {is_last, data_byte}

	sample_decode_scoreboard tracker;

	mod_delta_sample_stream_decoder #(
		.NUM_INSTRUMENTS(NUM_INSTR),
		.NUM_VOICES     (VOICES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #6 clk = ~clk;

	// Mostly short gaps, now and then a long one; none during calm stretches
	function automatic int unsigned idle_len(int unsigned zero_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < zero_pct) return 0;
		if (r < zero_pct + (100 - zero_pct) * 3 / 4) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One input transfer, preceded by a random gap
	task automatic send_byte(input logic [7:0] data, input logic last);
		int unsigned gap;
		gap = idle_len(60);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		tracker.take_input(data, last);
	endtask

	// Output side: score each transfer, then pick the next tready
	initial begin : receiver
		int unsigned stall_left;
		stall_left = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				tracker.check_result(m_axis_tdata, m_axis_tuser);
				results_seen++;
			end
			if (hold_off) begin
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				stall_left    = idle_len(80);
				m_axis_tready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	// Long receiver hold-off mid-pattern so the queue fills and s_axis stalls
	initial begin : backpressure
		wait (results_seen >= 1500);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin : watchdog
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still owed", LIMIT_CYCLES,
			tracker.pending());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main
		logic [15:0] words [NUM_INSTR];
		int unsigned body;
		int unsigned sample_bytes;
		int unsigned n;
		tracker      = new();
		sample_bytes = 0;

		// Length words: empty first, wrap to zero, two 2-byte samples, small ones,
		// then a random mix and three empty instruments at the end
		words[0] = 16'h0000;
		words[1] = 16'h8000;
		words[2] = 16'h0001;
		words[3] = 16'h8001;
		words[4] = 16'h0002;
		words[5] = 16'h0003;
		for (n = 6; n < NUM_INSTR; n++) begin
			if (n >= NUM_INSTR - 3 || $urandom_range(0, 3) == 0)
				words[n] = 16'h0000;
			else
				words[n] = {($urandom_range(0, 1) != 0) ? 8'h80 : 8'h00,
					8'($urandom_range(1, 6))};
		end

		// Header: title, instrument records, song length and restart
		repeat (TITLE_BYTES) stim_q.push_back({1'b0, 8'($urandom)});
		for (n = 0; n < NUM_INSTR; n++) begin
			for (int r = 0; r < INSTR_REC_BYTES; r++) begin
				if (r == LEN_HI_POS)
					stim_q.push_back({1'b0, words[n][15:8]});
				else if (r == LEN_LO_POS)
					stim_q.push_back({1'b0, words[n][7:0]});
				else
					stim_q.push_back({1'b0, 8'($urandom)});
			end
		end
		repeat (2) stim_q.push_back({1'b0, 8'($urandom)});
		// Sequence table tops out at TOP_PATTERN, so TOP_PATTERN + 1 patterns follow
		for (n = 0; n < SEQUENCE_LENGTH; n++)
			stim_q.push_back({1'b0, (n == 5 || $urandom_range(0, 7) == 0) ?
				8'(TOP_PATTERN) : 8'd0});
		repeat (TAG_BYTES) stim_q.push_back({1'b0, 8'($urandom)});
		repeat ((TOP_PATTERN + 1) * PAT_BYTES) stim_q.push_back({1'b0, 8'($urandom)});
		// Sample bodies, then the true last byte of the file
		for (n = 0; n < NUM_INSTR; n++) begin
			body = {words[n][14:0], 1'b0};
			sample_bytes += body;
			repeat (body) stim_q.push_back({1'b0, 8'($urandom)});
		end
		stim_q[stim_q.size() - 1][8] = 1'b1;
		repeat (TAIL_BYTES) stim_q.push_back({1'b0, 8'($urandom)});

		// Stray end flags: inside the header, inside the patterns, and at random
		stim_q[0][8]             = 1'b1;
		stim_q[HDR_BYTES + 7][8] = 1'b1;
		foreach (stim_q[i])
			if ($urandom_range(0, 99) == 0) stim_q[i][8] = 1'b1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < stim_q.size(); n++) begin
			calm = (n >= 400 && n < 900);
			send_byte(stim_q[n][7:0], stim_q[n][8]);
		end
		s_axis_tvalid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("streamed %0d bytes: %0d header, %0d pattern, %0d sample, %0d trailing",
			stim_q.size(), HDR_BYTES, (TOP_PATTERN + 1) * PAT_BYTES, sample_bytes, TAIL_BYTES);
		$display("scored %0d output transfers, %0d end-of-file flags, %0d failures",
			tracker.checked, tracker.flags_seen, tracker.failures);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/mdsd_pkg.sv
hdl/mdsd_front.sv
hdl/mdsd_queue.sv
hdl/mdsd_back.sv
hdl/mod_delta_sample_stream_decoder.sv
tb/mod_delta_sample_stream_decoder_test.sv
